// ===== rtl/dsu_pkg.sv =====
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants of the disjoint-set union engine: element
// count, field widths, the node table entry, and controller/datapath links.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int unsigned NODES = 1024;
  localparam int unsigned IDX_W = $clog2(NODES);
  localparam int unsigned CNT_W = $clog2(NODES + 1);

  // One node table entry. Count, high and low are meaningful at roots only.
  typedef struct packed {
    logic [IDX_W-1:0] parent;
    logic [CNT_W-1:0] count;
    logic [IDX_W-1:0] high;
    logic [IDX_W-1:0] low;
  } dsu_entry_t;

  localparam int unsigned ENTRY_W = $bits(dsu_entry_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;  // write reset entry at the clear counter, advance it
    logic accept;    // capture the transaction, start walking from node_a
    logic chk_a;     // evaluate read data while walking node_a's chain
    logic chk_b;     // evaluate read data while walking node_b's chain
    logic merge;     // link the smaller root, latch the combined entry
    logic wr_big;    // write the combined entry at the surviving root
    logic out_load;  // load the result register
  } dsu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // clear counter at the last entry
    logic is_root;   // entry just read points to itself
    logic out_free;  // result register can take a new transaction
  } dsu_status_t;

endpackage

// ===== rtl/dsu_ram.sv =====
// ----------------------------------------------------------------------------
// dsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/dsu_datapath.sv =====
// ----------------------------------------------------------------------------
// dsu_datapath
// Node table, root walk registers, merge logic and result register of the
// disjoint-set union engine. Driven step by step by dsu_ctrl.
// ----------------------------------------------------------------------------
module dsu_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dsu_pkg::IDX_W-1:0]   node_a_i,
  input  logic [dsu_pkg::IDX_W-1:0]   node_b_i,
  input  logic                        out_stall_i,
  input  dsu_pkg::dsu_cmd_t           cmd_i,
  output dsu_pkg::dsu_status_t        status_o,
  output logic                        out_valid_o,
  output logic                        merged_o,
  output logic [dsu_pkg::CNT_W-1:0]   group_size_o,
  output logic [dsu_pkg::IDX_W-1:0]   group_min_o,
  output logic [dsu_pkg::IDX_W-1:0]   group_max_o,
  output logic [dsu_pkg::CNT_W-1:0]   largest_size_o
);

  import dsu_pkg::*;

  logic [IDX_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0] b_q, b_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] ra_q, ra_d;
  logic [IDX_W-1:0] rb_q, rb_d;
  dsu_entry_t       ea_q, ea_d;
  dsu_entry_t       eb_q, eb_d;
  dsu_entry_t       res_q, res_d;
  logic [IDX_W-1:0] res_root_q, res_root_d;
  logic             merged_q, merged_d;

  logic             out_valid_q, out_valid_d;
  logic             out_merged_q, out_merged_d;
  logic [CNT_W-1:0] out_size_q, out_size_d;
  logic [IDX_W-1:0] out_min_q, out_min_d;
  logic [IDX_W-1:0] out_max_q, out_max_d;
  logic [CNT_W-1:0] largest_q, largest_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  dsu_entry_t       ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  dsu_entry_t       rd_entry;

  // merge terms
  logic             differ;
  logic             a_smaller;
  dsu_entry_t       big_e, small_e;
  logic [IDX_W-1:0] big_r, small_r;
  logic [CNT_W-1:0] sum;
  dsu_entry_t       joined_e;

  dsu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NODES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cur_q),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = dsu_entry_t'(ram_rdata);

  always_comb begin
    differ    = (ra_q != rb_q);
    a_smaller = (ea_q.count < eb_q.count);
    big_e     = a_smaller ? eb_q : ea_q;
    small_e   = a_smaller ? ea_q : eb_q;
    big_r     = a_smaller ? rb_q : ra_q;
    small_r   = a_smaller ? ra_q : rb_q;
    sum       = big_e.count + small_e.count;

    joined_e.parent = big_r;
    joined_e.count  = sum;
    joined_e.high   = (small_e.high > big_e.high) ? small_e.high : big_e.high;
    joined_e.low    = (small_e.low < big_e.low) ? small_e.low : big_e.low;
  end

  // table write port: clearing pass, link of the smaller root, combined root
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_q;
    ram_wdata.parent = clr_cnt_q;
    ram_wdata.count  = CNT_W'(1);
    ram_wdata.high   = clr_cnt_q;
    ram_wdata.low    = clr_cnt_q;
    priority if (cmd_i.clr_step) begin
      ram_we = 1'b1;
    end else if (cmd_i.merge) begin
      ram_we           = differ;
      ram_waddr        = small_r;
      ram_wdata        = small_e;
      ram_wdata.parent = big_r;
    end else if (cmd_i.wr_big) begin
      ram_we    = merged_q;
      ram_waddr = res_root_q;
      ram_wdata = res_q;
    end
  end

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    b_d        = b_q;
    cur_d      = cur_q;
    ra_d       = ra_q;
    rb_d       = rb_q;
    ea_d       = ea_q;
    eb_d       = eb_q;
    res_d      = res_q;
    res_root_d = res_root_q;
    merged_d   = merged_q;

    if (cmd_i.clr_step) begin
      clr_cnt_d = clr_cnt_q + IDX_W'(1);
    end
    if (cmd_i.accept) begin
      cur_d = node_a_i;
      b_d   = node_b_i;
    end
    if (cmd_i.chk_a) begin
      if (status_o.is_root) begin
        ra_d  = cur_q;
        ea_d  = rd_entry;
        cur_d = b_q;
      end else begin
        cur_d = rd_entry.parent;
      end
    end
    if (cmd_i.chk_b) begin
      if (status_o.is_root) begin
        rb_d = cur_q;
        eb_d = rd_entry;
      end else begin
        cur_d = rd_entry.parent;
      end
    end
    if (cmd_i.merge) begin
      merged_d   = differ;
      res_d      = differ ? joined_e : ea_q;
      res_root_d = differ ? big_r : ra_q;
    end
  end

  // result register: hold while stalled, take the next transaction when free
  always_comb begin
    out_valid_d  = out_valid_q;
    out_merged_d = out_merged_q;
    out_size_d   = out_size_q;
    out_min_d    = out_min_q;
    out_max_d    = out_max_q;
    largest_d    = largest_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.out_load) begin
      out_valid_d  = 1'b1;
      out_merged_d = merged_q;
      out_size_d   = res_q.count;
      out_min_d    = res_q.low;
      out_max_d    = res_q.high;
      if (res_q.count > largest_q) begin
        largest_d = res_q.count;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      largest_q   <= CNT_W'(1);
    end else begin
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      largest_q   <= largest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q          <= b_d;
    cur_q        <= cur_d;
    ra_q         <= ra_d;
    rb_q         <= rb_d;
    ea_q         <= ea_d;
    eb_q         <= eb_d;
    res_q        <= res_d;
    res_root_q   <= res_root_d;
    merged_q     <= merged_d;
    out_merged_q <= out_merged_d;
    out_size_q   <= out_size_d;
    out_min_q    <= out_min_d;
    out_max_q    <= out_max_d;
  end

  assign status_o.clr_last = (clr_cnt_q == IDX_W'(NODES - 1));
  assign status_o.is_root  = (rd_entry.parent == cur_q);
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign merged_o       = out_merged_q;
  assign group_size_o   = out_size_q;
  assign group_min_o    = out_min_q;
  assign group_max_o    = out_max_q;
  assign largest_size_o = largest_q;

endmodule

// ===== rtl/dsu_ctrl.sv =====
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer of the disjoint-set union engine: clearing pass, two root walks,
// merge writes and result hand-off.
// ----------------------------------------------------------------------------
module dsu_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  dsu_pkg::dsu_status_t status_i,
  output dsu_pkg::dsu_cmd_t    cmd_o
);

  import dsu_pkg::*;

  typedef enum logic [8:0] {
    S_CLEAR  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_RD_A   = 9'b000000100,
    S_CHK_A  = 9'b000001000,
    S_RD_B   = 9'b000010000,
    S_CHK_B  = 9'b000100000,
    S_MERGE  = 9'b001000000,
    S_WR_BIG = 9'b010000000,
    S_DONE   = 9'b100000000
  } dsu_state_e;

  dsu_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_RD_A;
        end
      end
      S_RD_A: begin
        state_d = S_CHK_A;
      end
      S_CHK_A: begin
        cmd_o.chk_a = 1'b1;
        state_d     = status_i.is_root ? S_RD_B : S_RD_A;
      end
      S_RD_B: begin
        state_d = S_CHK_B;
      end
      S_CHK_B: begin
        cmd_o.chk_b = 1'b1;
        state_d     = status_i.is_root ? S_MERGE : S_RD_B;
      end
      S_MERGE: begin
        cmd_o.merge = 1'b1;
        state_d     = S_WR_BIG;
      end
      S_WR_BIG: begin
        cmd_o.wr_big = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        // wait for the result register to drain
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

// ===== rtl/disjoint_set_union_by_size_top.sv =====
// ----------------------------------------------------------------------------
// disjoint_set_union_by_size_top
// Union-find engine with union by size; reports merge flag, group size,
// group min/max and the running largest group size per transaction.
// ----------------------------------------------------------------------------
// Sequence: accept, then a walk of node_a's chain and of node_b's chain, each
//   reading and checking every table entry visited (root included), then
//   link, root write and result load; link depths are at most log2(NODES) = 10.
// Throughput: one transaction at a time; in_stall_o stays high until its result is loaded.
// Reset: a clearing pass fills every entry of the node table; in_stall_o is high
//   during the pass.
module disjoint_set_union_by_size_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [dsu_pkg::IDX_W-1:0] node_a_i,
  input  logic [dsu_pkg::IDX_W-1:0] node_b_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      merged_o,
  output logic [dsu_pkg::CNT_W-1:0] group_size_o,
  output logic [dsu_pkg::IDX_W-1:0] group_min_o,
  output logic [dsu_pkg::IDX_W-1:0] group_max_o,
  output logic [dsu_pkg::CNT_W-1:0] largest_size_o
);

  import dsu_pkg::*;

  dsu_cmd_t    cmd;
  dsu_status_t status;

  dsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  dsu_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .node_a_i       (node_a_i),
    .node_b_i       (node_b_i),
    .out_stall_i    (out_stall_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_valid_o    (out_valid_o),
    .merged_o       (merged_o),
    .group_size_o   (group_size_o),
    .group_min_o    (group_min_o),
    .group_max_o    (group_max_o),
    .largest_size_o (largest_size_o)
  );

endmodule

// ===== rtl/dsu_checker.sv =====
// ----------------------------------------------------------------------------
// dsu_checker
// Port-level checks of the disjoint-set union engine, bound to the top level.
// ----------------------------------------------------------------------------
module dsu_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic                      merged_o,
  input logic [dsu_pkg::CNT_W-1:0] group_size_o,
  input logic [dsu_pkg::IDX_W-1:0] group_min_o,
  input logic [dsu_pkg::IDX_W-1:0] group_max_o,
  input logic [dsu_pkg::CNT_W-1:0] largest_size_o
);

  import dsu_pkg::*;

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_merge_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && merged_o |-> group_size_o >= CNT_W'(2))
    else $error("merged group smaller than two");

  a_largest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> largest_size_o >= group_size_o)
    else $error("largest size below group size");

  a_min_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> group_min_o <= group_max_o)
    else $error("group min above group max");

endmodule

bind disjoint_set_union_by_size_top dsu_checker u_dsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .merged_o       (merged_o),
  .group_size_o   (group_size_o),
  .group_min_o    (group_min_o),
  .group_max_o    (group_max_o),
  .largest_size_o (largest_size_o)
);
